// ===== sv/naca_pkg.sv =====
// Package for the NACA airfoil cell mask: fixed-point constants and shared types.
// No dependencies.
`default_nettype none
package naca_pkg;
  localparam int FRAC = 16;
  localparam logic [16:0] ONE_F   = 17'd65536;
  localparam logic [16:0] K_SQ    = 17'd19458;
  localparam logic [16:0] K_X1    = 17'd8258;
  localparam logic [16:0] K_X2    = 17'd23042;
  localparam logic [16:0] K_X3    = 17'd18632;
  localparam logic [16:0] K_X4    = 17'd6652;
  localparam logic [16:0] K_THK   = 17'd39322;
  localparam logic [16:0] K_FLR   = 17'd52429;
  localparam logic [16:0] K_P     = 17'd26214;
  localparam logic [16:0] K_E8    = 17'd52429;
  localparam logic [16:0] K_E2    = 17'd13107;
  localparam logic [16:0] K_FRONT = 17'd8192;
  localparam logic [16:0] K_REAR  = 17'd3641;

  localparam logic [2:0] REG_W  = 3'd0;
  localparam logic [2:0] REG_H  = 3'd1;
  localparam logic [2:0] REG_DX = 3'd2;
  localparam logic [2:0] REG_CH = 3'd3;
  localparam logic [2:0] REG_CR = 3'd4;
  localparam logic [2:0] REG_LX = 3'd5;
  localparam logic [2:0] REG_MY = 3'd6;

  typedef struct packed {
    logic [12:0] grid_width;
    logic [12:0] grid_height;
    logic [30:0] cell_size;
    logic [30:0] chord_len;
    logic [31:0] chord_recip;
    logic [30:0] lead_x;
    logic [30:0] mid_y;
  } cfg_t;
endpackage
`default_nettype wire

// ===== sv/naca_regs.sv =====
// APB register file for the airfoil mask configuration.
// Depends on naca_pkg.
`default_nettype none
module naca_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output naca_pkg::cfg_t        cfg
);
  logic wr;
  logic [2:0] idx;
  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width  <= 13'd256;
      cfg.grid_height <= 13'd256;
      cfg.cell_size   <= 31'd65536;
      cfg.chord_len   <= 31'd6710886;
      cfg.chord_recip <= 32'd41943040;
      cfg.lead_x      <= 31'd3355443;
      cfg.mid_y       <= 31'd8388608;
    end else if (wr) begin
      case (idx)
        naca_pkg::REG_W:  cfg.grid_width  <= pwdata[12:0];
        naca_pkg::REG_H:  cfg.grid_height <= pwdata[12:0];
        naca_pkg::REG_DX: cfg.cell_size   <= pwdata[30:0];
        naca_pkg::REG_CH: cfg.chord_len   <= pwdata[30:0];
        naca_pkg::REG_CR: cfg.chord_recip <= pwdata;
        naca_pkg::REG_LX: cfg.lead_x      <= pwdata[30:0];
        naca_pkg::REG_MY: cfg.mid_y       <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (idx)
      naca_pkg::REG_W:  prdata = {19'd0, cfg.grid_width};
      naca_pkg::REG_H:  prdata = {19'd0, cfg.grid_height};
      naca_pkg::REG_DX: prdata = {1'b0, cfg.cell_size};
      naca_pkg::REG_CH: prdata = {1'b0, cfg.chord_len};
      naca_pkg::REG_CR: prdata = cfg.chord_recip;
      naca_pkg::REG_LX: prdata = {1'b0, cfg.lead_x};
      naca_pkg::REG_MY: prdata = {1'b0, cfg.mid_y};
      default: prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/naca_sqrt.sv =====
// Pipelined floor square root of a 33-bit radicand, one result bit per stage.
// Runs alongside the main datapath with the same enable; no package use.
`default_nettype none
module naca_sqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [16:0] xc,
  output logic      [16:0] root
);
  // radicand is xc << 16; 17 stages, root bit 16 down to 0
  logic [33:0] rem [0:17];
  logic [16:0] res [0:17];
  logic [33:0] vin [0:17];

  assign rem[0] = 34'd0;
  assign res[0] = 17'd0;
  assign vin[0] = {1'b0, xc, 16'd0};

  for (genvar s = 0; s < 17; s++) begin : g_st
    logic [33:0] trial;
    logic [33:0] rsh;
    assign rsh   = {rem[s][31:0], vin[s][33:32]};
    assign trial = {15'd0, res[s], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        vin[s+1] <= {vin[s][31:0], 2'b00};
        if (rsh >= trial) begin
          rem[s+1] <= rsh - trial;
          res[s+1] <= {res[s][15:0], 1'b1};
        end else begin
          rem[s+1] <= rsh;
          res[s+1] <= {res[s][15:0], 1'b0};
        end
      end
    end
  end
  assign root = res[17];
endmodule
`default_nettype wire

// ===== sv/naca_core.sv =====
// Deep pipeline computing the airfoil solid bit for one cell per clock while en is high.
// Depends on naca_pkg and naca_sqrt.
`default_nettype none
module naca_core #(
  parameter int MAX_GRID = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [11:0]    cx,
  input  wire logic [11:0]    cy,
  input  naca_pkg::cfg_t      cfg,
  output logic                out_valid,
  output logic                out_solid
);
  // S1..S5, 17 root stages, then five stages to the solid bit
  localparam int LAT = 27;
  localparam logic [16:0] MAXG = 17'(MAX_GRID);

  // valid shift line
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end
  assign out_valid = vld[LAT-1];

  // S1: border test, products
  logic        ok1;
  logic signed [44:0] px1, py1;
  logic [16:0] w, h;
  always_comb begin
    w = ({4'd0, cfg.grid_width} > MAXG) ? MAXG : {4'd0, cfg.grid_width};
    h = ({4'd0, cfg.grid_height} > MAXG) ? MAXG : {4'd0, cfg.grid_height};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ok1 <= cx != 12'd0 && cy != 12'd0 && ({5'd0, cx} + 17'd1 < w) &&
             ({5'd0, cy} + 17'd1 < h);
      px1 <= $signed({2'b0, 43'(cx * cfg.cell_size)});
      py1 <= $signed({2'b0, 43'(cy * cfg.cell_size)});
    end
  end

  // S2: offsets
  logic ok2;
  logic signed [44:0] px2, py2;
  always_ff @(posedge clk) begin
    if (en) begin
      px2 <= px1 - $signed({14'd0, cfg.lead_x});
      py2 <= py1 - $signed({14'd0, cfg.mid_y});
      ok2 <= ok1;
    end
  end

  // S3: chord range check
  logic ok3;
  logic [30:0] pxu3;
  logic signed [44:0] py3;
  always_ff @(posedge clk) begin
    if (en) begin
      ok3 <= ok2 && !px2[44] && (px2 <= $signed({14'd0, cfg.chord_len}));
      pxu3 <= px2[30:0];
      py3 <= py2;
    end
  end

  // S4: xc = px*recip >> 32 split into two 16-bit halves of recip
  logic [46:0] plo4, phi4;
  logic ok4;
  logic signed [44:0] py4;
  always_ff @(posedge clk) begin
    if (en) begin
      plo4 <= 47'(pxu3 * cfg.chord_recip[15:0]);
      phi4 <= 47'(pxu3 * cfg.chord_recip[31:16]);
      ok4 <= ok3; py4 <= py3;
    end
  end

  // S5: combine and saturate
  logic [16:0] xc5;
  logic ok5;
  logic signed [44:0] py5;
  logic [63:0] prod;
  assign prod = {1'b0, phi4, 16'd0} + {17'd0, plo4};
  always_ff @(posedge clk) begin
    if (en) begin
      xc5 <= (prod[63:32] > 32'(naca_pkg::ONE_F)) ? naca_pkg::ONE_F : prod[48:32];
      ok5 <= ok4; py5 <= py4;
    end
  end

  // square root runs 17 stages from S5 output
  logic [16:0] sq;
  naca_sqrt u_sqrt (.clk(clk), .en(en), .xc(xc5), .root(sq));

  // powers pipeline, aligned to sqrt via delay line (17 stages)
  localparam int D = 17;
  logic [16:0] xcd [0:D];
  logic [33:0] x2d [0:D];
  logic [33:0] x3d [0:D];
  logic [33:0] x4d [0:D];
  logic        okd [0:D];
  logic signed [44:0] pyd [0:D];
  assign xcd[0] = xc5; assign okd[0] = ok5; assign pyd[0] = py5;
  assign x2d[0] = '0; assign x3d[0] = '0; assign x4d[0] = '0;
  for (genvar s = 0; s < D; s++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        xcd[s+1] <= xcd[s];
        okd[s+1] <= okd[s];
        pyd[s+1] <= pyd[s];
        x2d[s+1] <= (s == 0) ? 34'((xcd[s] * xcd[s]) >> 16) : x2d[s];
        x3d[s+1] <= (s == 1) ? 34'((x2d[s][16:0] * xcd[s]) >> 16) : x3d[s];
        x4d[s+1] <= (s == 2) ? 34'((x3d[s][16:0] * xcd[s]) >> 16) : x4d[s];
      end
    end
  end

  // S+1: polynomial terms
  logic [33:0] t_sq, t_x1, t_x2, t_x3, t_x4;
  logic [16:0] xa;
  logic oka;
  logic signed [44:0] pya;
  always_ff @(posedge clk) begin
    if (en) begin
      t_sq <= 34'((naca_pkg::K_SQ * sq) >> 16);
      t_x1 <= 34'((naca_pkg::K_X1 * xcd[D]) >> 16);
      t_x2 <= 34'((naca_pkg::K_X2 * x2d[D][16:0]) >> 16);
      t_x3 <= 34'((naca_pkg::K_X3 * x3d[D][16:0]) >> 16);
      t_x4 <= 34'((naca_pkg::K_X4 * x4d[D][16:0]) >> 16);
      xa <= xcd[D]; oka <= okd[D]; pya <= pyd[D];
    end
  end

  // S+2: sum, camber inner
  logic signed [35:0] poly;
  logic [33:0] inner;
  logic front;
  logic okb;
  logic signed [44:0] pyb;
  logic [16:0] ia, ib;
  always_comb begin
    if (xa < naca_pkg::K_P) begin
      ia = xa; ib = naca_pkg::K_E8 - xa;
    end else begin
      ia = naca_pkg::ONE_F - xa; ib = xa + naca_pkg::K_E2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      poly <= $signed({2'b0, t_sq}) - $signed({2'b0, t_x1}) - $signed({2'b0, t_x2})
            + $signed({2'b0, t_x3}) - $signed({2'b0, t_x4});
      inner <= 34'((ia * ib) >> 16);
      front <= xa < naca_pkg::K_P;
      okb <= oka; pyb <= pya;
    end
  end

  // S+3: scale by constants
  logic [33:0] tk, cb;
  logic okc;
  logic signed [44:0] pyc;
  always_ff @(posedge clk) begin
    if (en) begin
      tk <= poly[35] ? 34'd0 : 34'((naca_pkg::K_THK * poly[16:0]) >> 16);
      cb <= 34'(((front ? naca_pkg::K_FRONT : naca_pkg::K_REAR) * inner[16:0]) >> 16);
      okc <= okb; pyc <= pyb;
    end
  end

  // S+4: multiply by chord, thickness floor
  logic [47:0] yt0, yc0, flr;
  logic okd2;
  logic signed [44:0] pye;
  always_ff @(posedge clk) begin
    if (en) begin
      yt0 <= 48'((cfg.chord_len * tk[16:0]) >> 16);
      yc0 <= 48'((cfg.chord_len * cb[16:0]) >> 16);
      flr <= 48'((cfg.cell_size * naca_pkg::K_FLR) >> 16);
      okd2 <= okc; pye <= pyc;
    end
  end

  // S+5: compare
  logic signed [49:0] yt, lo, hi, pyx;
  always_comb begin
    yt  = $signed({2'b0, (yt0 < flr) ? flr : yt0});
    hi  = $signed({2'b0, yc0}) + yt;
    lo  = $signed({2'b0, yc0}) - yt;
    pyx = 50'(pye);
  end
  always_ff @(posedge clk) begin
    if (en) out_solid <= okd2 && (pyx <= hi) && (pyx >= lo);
  end
endmodule
`default_nettype wire

// ===== sv/naca_airfoil_cell_mask.sv =====
// NACA 2412 cell mask top level: APB registers, stream ports, core pipeline.
// An accepted input passes the core pipeline, then the output register, before valid output.
// Throughput is one cell per clock; a stalled output holds the whole pipeline.
// Synchronous active-high reset clears valid bits and restores default registers.
`default_nettype none
module naca_airfoil_cell_mask #(
  parameter int MAX_GRID = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // cell_x [11:0], cell_y [23:12]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // solid [0], zero fill [7:1]
);
  naca_pkg::cfg_t cfg;
  logic en, ov, os;

  naca_regs u_regs (.clk(clk), .rst(rst), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready), .cfg(cfg));

  // advance when output slot empty or being taken
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  naca_core #(.MAX_GRID(MAX_GRID)) u_core (.clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .cx(s_tdata[11:0]), .cy(s_tdata[23:12]), .cfg(cfg),
    .out_valid(ov), .out_solid(os));

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= ov;
  end
  always_ff @(posedge clk) begin
    if (en) m_tdata <= {7'd0, os};
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready)) else $error("ready");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:1] == 7'd0) else $error("pad");
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for naca_airfoil_cell_mask: streams grid cells, predicts the solid bit.
// Depends on naca_pkg (register indexes and constants) and the top-level RTL.
`default_nettype none
module tb;
  localparam longint MAX_GRID_TB = 4096;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  naca_airfoil_cell_mask u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // shadow copy of the registers
  logic [12:0] g_w, g_h;
  logic [30:0] g_dx, g_ch, g_lx, g_my;
  logic [31:0] g_cr;

  logic [23:0] cell_q[$];
  bit          solid_q[$];
  int          errors = 0;
  int          n_sent = 0, n_seen = 0, n_solid = 0;
  bit          rx_stall_on = 1'b1;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[79:16];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit airfoil_solid(logic [11:0] ci, logic [11:0] cj);
    longint w, h, px, py, yt, yc, poly, flr;
    logic [63:0] xc, x2, x3, x4, sq, inn;
    logic [127:0] prod;
    w = (g_w > MAX_GRID_TB) ? MAX_GRID_TB : g_w;
    h = (g_h > MAX_GRID_TB) ? MAX_GRID_TB : g_h;
    if (ci == 0 || cj == 0 || ci + 1 >= w || cj + 1 >= h) return 1'b0;
    px = longint'(ci) * longint'(g_dx) - longint'(g_lx);
    py = longint'(cj) * longint'(g_dx) - longint'(g_my);
    if (px < 0 || px > longint'(g_ch)) return 1'b0;
    prod = 128'(px) * 128'(g_cr);
    xc = prod[95:32];
    if (xc > 64'(naca_pkg::ONE_F)) xc = 64'(naca_pkg::ONE_F);
    x2 = fmul(xc, xc);
    x3 = fmul(x2, xc);
    x4 = fmul(x3, xc);
    sq = root_floor(xc << 16);
    poly = longint'(fmul(naca_pkg::K_SQ, sq)) - longint'(fmul(naca_pkg::K_X1, xc))
         - longint'(fmul(naca_pkg::K_X2, x2))
         + longint'(fmul(naca_pkg::K_X3, x3)) - longint'(fmul(naca_pkg::K_X4, x4));
    if (poly < 0) poly = 0;
    yt = longint'(fmul(g_ch, fmul(naca_pkg::K_THK, poly)));
    flr = longint'(fmul(g_dx, naca_pkg::K_FLR));
    if (yt < flr) yt = flr;
    if (xc < naca_pkg::K_P) begin
      inn = fmul(xc, 64'(naca_pkg::K_E8) - xc);
      yc = longint'(fmul(g_ch, fmul(naca_pkg::K_FRONT, inn)));
    end else begin
      inn = fmul(64'(naca_pkg::ONE_F) - xc, xc + naca_pkg::K_E2);
      yc = longint'(fmul(g_ch, fmul(naca_pkg::K_REAR, inn)));
    end
    return (py <= yc + yt) && (py >= yc - yt);
  endfunction

  // driver: one cell per transaction, random gaps between them
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_tready) begin
      // hold
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      s_tvalid <= 1'b0;
    end else if (cell_q.size() > 0) begin
      s_tdata <= cell_q[0];
      solid_q.push_back(airfoil_solid(cell_q[0][11:0], cell_q[0][23:12]));
      void'(cell_q.pop_front());
      s_tvalid <= 1'b1;
      n_sent <= n_sent + 1;
      tx_gap <= gap_len();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  int rx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_seen <= n_seen + 1;
        if (solid_q.size() == 0) begin
          $error("unexpected result: solid=%0d", m_tdata[0]);
          errors <= errors + 1;
        end else begin
          if (m_tdata[0] !== solid_q[0]) begin
            $error("solid mismatch: expected %0d, actual %0d", solid_q[0], m_tdata[0]);
            errors <= errors + 1;
          end
          if (m_tdata[0]) n_solid <= n_solid + 1;
          void'(solid_q.pop_front());
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (rx_stall_on) rx_gap <= gap_len();
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      naca_pkg::REG_W:  g_w  = val[12:0];
      naca_pkg::REG_H:  g_h  = val[12:0];
      naca_pkg::REG_DX: g_dx = val[30:0];
      naca_pkg::REG_CH: g_ch = val[30:0];
      naca_pkg::REG_CR: g_cr = val;
      naca_pkg::REG_LX: g_lx = val[30:0];
      naca_pkg::REG_MY: g_my = val[30:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (cell_q.size() == 0 && solid_q.size() == 0 && !s_tvalid);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [23:0] pack_cell(int x, int y);
    return {12'(y), 12'(x)};
  endfunction

  // consistent airfoil geometry for a grid of w x h cells with spacing dx
  task automatic set_geometry(int w, int h, longint dx);
    longint ch;
    ch = (dx * w * 2) / 5;
    if (ch < 1) ch = 1;
    if (ch > 64'h7fffffff) ch = 64'h7fffffff;
    reg_write(naca_pkg::REG_W, w);
    reg_write(naca_pkg::REG_H, h);
    reg_write(naca_pkg::REG_DX, 32'(dx));
    reg_write(naca_pkg::REG_CH, 32'(ch));
    reg_write(naca_pkg::REG_CR, 32'((64'd1 << 48) / ch > 64'hffffffff ? 64'hffffffff
                                    : (64'd1 << 48) / ch));
    reg_write(naca_pkg::REG_LX, 32'((dx * w) / 5));
    reg_write(naca_pkg::REG_MY, 32'((dx * h) / 2));
  endtask

  // mostly cells around the airfoil, some anywhere in the index range
  task automatic random_cells(int n, int w, int h);
    int x, y;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        x = $urandom_range(w / 6, (w * 2) / 3);
        y = $urandom_range((h * 2) / 5, (h * 3) / 5);
      end else begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
      end
      cell_q.push_back(pack_cell(x, y));
    end
  endtask

  initial begin
    g_w = 256; g_h = 256; g_dx = 65536; g_ch = 6710886;
    g_cr = 41943040; g_lx = 3355443; g_my = 8388608;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: borders, leading and trailing edge, camber split, extremes
    cell_q.push_back(pack_cell(0, 128));
    cell_q.push_back(pack_cell(255, 128));
    cell_q.push_back(pack_cell(254, 128));
    cell_q.push_back(pack_cell(100, 0));
    cell_q.push_back(pack_cell(100, 255));
    cell_q.push_back(pack_cell(4095, 4095));
    cell_q.push_back(pack_cell(51, 128));
    cell_q.push_back(pack_cell(52, 128));
    cell_q.push_back(pack_cell(153, 128));
    cell_q.push_back(pack_cell(154, 128));
    cell_q.push_back(pack_cell(92, 128));
    cell_q.push_back(pack_cell(92, 131));
    cell_q.push_back(pack_cell(92, 125));
    cell_q.push_back(pack_cell(70, 129));
    cell_q.push_back(pack_cell(130, 128));
    cell_q.push_back(pack_cell(1, 1));
    cell_q.push_back(pack_cell(2730, 1365));
    drain();

    // reciprocal far too large: xc saturates at one
    reg_write(naca_pkg::REG_CR, 32'hffffffff);
    for (int x = 50; x < 160; x += 4) cell_q.push_back(pack_cell(x, 128));
    drain();

    // grid below the minimum: every cell border; then sizes past MAX_GRID
    reg_write(naca_pkg::REG_W, 2);
    reg_write(naca_pkg::REG_H, 13'h1fff);
    random_cells(40, 256, 256);
    drain();

    set_geometry(256, 256, 65536);
    random_cells(500, 256, 256);
    drain();
    set_geometry(4096, 4096, 4096);
    random_cells(400, 4096, 4096);
    drain();
    set_geometry(3, 3, 65536);
    cell_q.push_back(pack_cell(1, 1));
    random_cells(30, 3, 3);
    drain();
    set_geometry(40, 24, 32'h7fffffff / 4096);
    random_cells(300, 40, 24);
    drain();
    // extremes of the geometry registers
    reg_write(naca_pkg::REG_W, 4096); reg_write(naca_pkg::REG_H, 4096);
    reg_write(naca_pkg::REG_DX, 1); reg_write(naca_pkg::REG_CH, 1);
    reg_write(naca_pkg::REG_CR, 1);
    reg_write(naca_pkg::REG_LX, 0); reg_write(naca_pkg::REG_MY, 0);
    random_cells(60, 4096, 4096);
    drain();
    reg_write(naca_pkg::REG_DX, 32'h7fffffff); reg_write(naca_pkg::REG_CH, 32'h7fffffff);
    reg_write(naca_pkg::REG_LX, 32'h7fffffff); reg_write(naca_pkg::REG_MY, 32'h7fffffff);
    random_cells(40, 4, 4);
    drain();
    set_geometry(1000, 600, 30000);
    rx_stall_on = 1'b0;
    random_cells(200, 1000, 600);
    drain();
    rx_stall_on = 1'b1;
    random_cells(300, 1000, 600);
    drain();

    $display("sent %0d and checked %0d cells through several grid geometries, %0d solid",
             n_sent, n_seen, n_solid);
    if (errors == 0 && solid_q.size() == 0)
      $display("** naca_airfoil_cell_mask: PASSED **");
    else
      $display("** naca_airfoil_cell_mask: FAILED **");
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout waiting for results");
    $display("** naca_airfoil_cell_mask: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
